// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define USFPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define USFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/usfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// usfpc_pkg
// Shared types, constants and helpers for the UDP source filter core.
// ----------------------------------------------------------------------------
package usfpc_pkg;

    localparam int PATTERN_MAX  = 16;
    localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
    localparam int PATTERN_CFG  = 16;

    localparam logic [15:0] POS_MAX        = 16'hFFFF;
    localparam logic [15:0] POS_ADDR_FIRST = 16'd12;
    localparam logic [15:0] POS_ADDR_LAST  = 16'd15;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] OFS_LEN_HI     = 16'd4;
    localparam logic [15:0] OFS_LEN_LO     = 16'd5;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_MATCH_ADDRESS  = 3'd0,
        REG_MATCH_PORT     = 3'd1,
        REG_PATTERN_HEAD   = 3'd2,
        REG_PATTERN_TAIL   = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_SAVE_LIMIT     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0]                  match_address;
        logic [15:0]                  match_port;
        logic [15:0]                  save_limit;
        logic [PATTERN_MAX-1:0][7:0]  pat_aligned;
        logic [PATTERN_MAX-1:0]       pat_mask;
        logic [LEN_W-1:0]             active_len;
    } cfg_t;

    typedef struct packed {
        logic [15:0] count;
        logic [31:0] address;
        logic [15:0] port;
    } fin_rec_t;

    function automatic logic [7:0] pattern_byte(input logic [63:0] head,
                                                input logic [63:0] tail,
                                                input logic [7:0]  j);
        logic [127:0] pat;
        pat = {tail, head};
        return (j < 8'(PATTERN_CFG)) ? pat[{j[3:0], 3'b000} +: 8] : 8'd0;
    endfunction

endpackage

// ===== hw/rtl/usfpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// usfpc_cfg_regs
// Configuration registers and the pattern aligned to the payload window.
// ----------------------------------------------------------------------------
module usfpc_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output usfpc_pkg::cfg_t     cfg
);
    import usfpc_pkg::*;

    logic [31:0] addr_reg,  addr_next;
    logic [15:0] port_reg,  port_next;
    logic [63:0] head_reg,  head_next;
    logic [63:0] tail_reg,  tail_next;
    logic [4:0]  len_reg,   len_next;
    logic [15:0] limit_reg, limit_next;
    logic [7:0]  len_clamped;

    assign cfg_ready = 1'b1;

    always_comb begin
        addr_next  = addr_reg;
        port_next  = port_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        len_next   = len_reg;
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MATCH_ADDRESS:  addr_next  = cfg_data[31:0];
                REG_MATCH_PORT:     port_next  = cfg_data[15:0];
                REG_PATTERN_HEAD:   head_next  = cfg_data;
                REG_PATTERN_TAIL:   tail_next  = cfg_data;
                REG_PATTERN_LENGTH: len_next   = cfg_data[4:0];
                REG_SAVE_LIMIT:     limit_next = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= '0;
            port_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            len_reg   <= 5'd1;
            limit_reg <= '0;
        end else begin
            addr_reg  <= addr_next;
            port_reg  <= port_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            limit_reg <= limit_next;
        end
    end

    // pattern byte i sits at window slot PATTERN_MAX - len + i
    always_comb begin
        len_clamped = {3'd0, len_reg};
        if (len_clamped == 8'd0) begin
            len_clamped = 8'd1;
        end else if (len_clamped > 8'(PATTERN_MAX)) begin
            len_clamped = 8'(PATTERN_MAX);
        end
        cfg.match_address = addr_reg;
        cfg.match_port    = port_reg;
        cfg.save_limit    = limit_reg;
        cfg.active_len    = LEN_W'(len_clamped);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (8'(k) + len_clamped >= 8'(PATTERN_MAX)) begin
                cfg.pat_mask[k]    = 1'b1;
                cfg.pat_aligned[k] = pattern_byte(head_reg, tail_reg,
                                         8'(k) + len_clamped - 8'(PATTERN_MAX));
            end else begin
                cfg.pat_mask[k]    = 1'b0;
                cfg.pat_aligned[k] = 8'd0;
            end
        end
    end

endmodule

// ===== hw/rtl/usfpc_parser.sv =====
// ----------------------------------------------------------------------------
// usfpc_parser
// Input register and per-byte header parse, payload window and match count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usfpc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  usfpc_pkg::cfg_t     cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_packet_byte,
    input  logic                s_end_of_packet,
    output logic                fin_push,
    output usfpc_pkg::fin_rec_t fin_rec,
    input  logic                fin_ready
);
    import usfpc_pkg::*;

    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_byte_reg;
    logic                         in_last_reg;
    logic [15:0]                  pos_reg,   pos_next;
    logic [5:0]                   hdr_reg,   hdr_next;
    logic [31:0]                  addr_reg,  addr_next;
    logic [15:0]                  port_reg,  port_next;
    logic [15:0]                  ulen_reg,  ulen_next;
    logic [PATTERN_MAX-1:0][7:0]  win_reg,   win_next;
    logic [LEN_W-1:0]             seen_reg,  seen_next;
    logic [15:0]                  count_reg, count_next;

    logic                         in_go;
    logic                         take;
    logic [5:0]                   hdr_cur;
    logic [15:0]                  h16;
    logic [31:0]                  addr_upd;
    logic [15:0]                  port_upd;
    logic [15:0]                  ulen_upd;
    logic [15:0]                  plen;
    logic                         in_payload;
    logic [PATTERN_MAX-1:0][7:0]  win_upd;
    logic [LEN_W-1:0]             seen_upd;
    logic [PATTERN_MAX-1:0]       slot_ok;
    logic                         hit;
    logic [15:0]                  count_upd;

    assign in_go   = in_valid_reg && (!in_last_reg || fin_ready);
    assign s_ready = !in_valid_reg || in_go;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_packet_byte;
            in_last_reg <= s_end_of_packet;
        end
    end

    always_comb begin
        take     = in_go && (pos_reg != POS_MAX);
        hdr_cur  = (pos_reg == 16'd0) ? {in_byte_reg[3:0], 2'b00} : hdr_reg;
        h16      = {10'd0, hdr_cur};

        addr_upd = addr_reg;
        if (pos_reg >= POS_ADDR_FIRST && pos_reg <= POS_ADDR_LAST) begin
            case (pos_reg[1:0])
                2'd0:    addr_upd[31:24] = in_byte_reg;
                2'd1:    addr_upd[23:16] = in_byte_reg;
                2'd2:    addr_upd[15:8]  = in_byte_reg;
                default: addr_upd[7:0]   = in_byte_reg;
            endcase
        end

        port_upd = port_reg;
        if (pos_reg == h16) begin
            port_upd[15:8] = in_byte_reg;
        end
        if (pos_reg == h16 + 16'd1) begin
            port_upd[7:0] = in_byte_reg;
        end

        ulen_upd = ulen_reg;
        if (pos_reg == h16 + OFS_LEN_HI) begin
            ulen_upd[15:8] = in_byte_reg;
        end
        if (pos_reg == h16 + OFS_LEN_LO) begin
            ulen_upd[7:0] = in_byte_reg;
        end

        plen       = (ulen_upd >= UDP_HDR_BYTES) ? ulen_upd - UDP_HDR_BYTES : 16'd0;
        in_payload = (pos_reg >= h16 + UDP_HDR_BYTES)
                     && (pos_reg - (h16 + UDP_HDR_BYTES) < plen);

        for (int k = 0; k < PATTERN_MAX - 1; k++) begin
            win_upd[k] = win_reg[k + 1];
        end
        win_upd[PATTERN_MAX-1] = in_byte_reg;
        seen_upd = (seen_reg < LEN_W'(PATTERN_MAX)) ? seen_reg + 1'b1 : seen_reg;

        for (int k = 0; k < PATTERN_MAX; k++) begin
            slot_ok[k] = !cfg.pat_mask[k] || (win_upd[k] == cfg.pat_aligned[k]);
        end
        hit       = (&slot_ok) && (seen_upd >= cfg.active_len);
        count_upd = (hit && count_reg != CNT_MAX) ? count_reg + 16'd1 : count_reg;
    end

    always_comb begin
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        addr_next  = addr_reg;
        port_next  = port_reg;
        ulen_next  = ulen_reg;
        win_next   = win_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        if (take) begin
            pos_next  = pos_reg + 16'd1;
            hdr_next  = hdr_cur;
            addr_next = addr_upd;
            port_next = port_upd;
            ulen_next = ulen_upd;
            if (in_payload) begin
                win_next   = win_upd;
                seen_next  = seen_upd;
                count_next = count_upd;
            end
        end

        fin_push      = in_go && in_last_reg;
        fin_rec.count   = count_next;
        fin_rec.address = addr_next;
        fin_rec.port    = port_next;

        if (fin_push) begin
            pos_next   = '0;
            hdr_next   = '0;
            addr_next  = '0;
            port_next  = '0;
            ulen_next  = '0;
            seen_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            hdr_reg   <= '0;
            addr_reg  <= '0;
            port_reg  <= '0;
            ulen_reg  <= '0;
            seen_reg  <= '0;
            count_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            addr_reg  <= addr_next;
            port_reg  <= port_next;
            ulen_reg  <= ulen_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    `USFPC_ASSERT(a_push_has_room, !fin_push || fin_ready,
                  "finish item pushed with no room")
    `USFPC_ASSERT_NEXT(a_count_only_in_payload, in_go && !in_payload && !in_last_reg,
                       $stable(count_reg) && $stable(seen_reg),
                       "match count moved outside the payload")

endmodule

// ===== hw/rtl/usfpc_result.sv =====
// ----------------------------------------------------------------------------
// usfpc_result
// Rule compare, save accounting and the result output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usfpc_result (
    input  logic                aclk,
    input  logic                aresetn,
    input  usfpc_pkg::cfg_t     cfg,
    input  logic                fin_push,
    input  usfpc_pkg::fin_rec_t fin_rec,
    output logic                fin_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_appearances,
    output logic                m_rule_hit,
    output logic                m_saved,
    output logic [15:0]         m_saved_index,
    output logic                m_limit_reached
);
    import usfpc_pkg::*;

    logic            fin_valid_reg, fin_valid_next;
    fin_rec_t        fin_reg;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     app_reg, idx_reg;
    logic            hit_reg, saved_reg, lim_reg;
    logic [15:0]     saved_cnt_reg, saved_cnt_next;

    logic            out_move;
    logic            fin_xfer;
    logic            rule_hit;
    logic [15:0]     appearances;
    logic            saved;

    assign out_move  = !out_valid_reg || m_ready;
    assign fin_ready = !fin_valid_reg || out_move;
    assign fin_xfer  = fin_valid_reg && out_move;

    always_comb begin
        rule_hit    = (fin_reg.address == cfg.match_address)
                      && (fin_reg.port == cfg.match_port);
        appearances = rule_hit ? fin_reg.count : 16'd0;
        saved       = (appearances != 16'd0) && (saved_cnt_reg < cfg.save_limit);

        saved_cnt_next = saved_cnt_reg;
        if (fin_xfer && saved) begin
            saved_cnt_next = saved_cnt_reg + 16'd1;
        end

        fin_valid_next = fin_valid_reg;
        if (fin_push) begin
            fin_valid_next = 1'b1;
        end else if (fin_xfer) begin
            fin_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fin_xfer) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            saved_cnt_reg <= '0;
        end else begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
            saved_cnt_reg <= saved_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_push) begin
            fin_reg <= fin_rec;
        end
        if (fin_xfer) begin
            app_reg   <= appearances;
            hit_reg   <= rule_hit;
            saved_reg <= saved;
            idx_reg   <= saved ? saved_cnt_reg : 16'd0;
            lim_reg   <= saved_cnt_next >= cfg.save_limit;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_appearances   = app_reg;
    assign m_rule_hit      = hit_reg;
    assign m_saved         = saved_reg;
    assign m_saved_index   = idx_reg;
    assign m_limit_reached = lim_reg;

    `USFPC_ASSERT(a_saved_needs_hit,
                  !(m_valid && m_saved) || (m_rule_hit && m_appearances != 16'd0),
                  "saved item without a rule hit or occurrences")
    `USFPC_ASSERT(a_saved_index_below_count,
                  !(m_valid && m_saved) || (m_saved_index < saved_cnt_reg),
                  "saved slot not below the saved count")
    `USFPC_ASSERT_NEXT(a_count_holds, !(fin_xfer && saved), $stable(saved_cnt_reg),
                       "saved count moved without a saved item")

endmodule

// ===== hw/rtl/udp_source_filter_pattern_counter_core.sv =====
// ----------------------------------------------------------------------------
// udp_source_filter_pattern_counter_core
// IPv4/UDP source filter that counts pattern occurrences in the UDP payload.
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle, back to back, including across packet
// boundaries; the rate rests on the combinational parse and window compare
// in the parser, which can update its header fields, 16-byte payload window
// and occurrence count on any byte. The last byte of a packet yields one
// result; m_valid rises once that byte has passed the input register, the
// finish register and the output register. Bytes keep flowing while a
// result waits on m_ready; a last byte stalls the input only while both
// result stages are full. Configuration writes are taken every cycle and
// must be made while no packet is in flight.
module udp_source_filter_pattern_counter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_end_of_packet,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_appearances,
    output logic        m_rule_hit,
    output logic        m_saved,
    output logic [15:0] m_saved_index,
    output logic        m_limit_reached
);
    import usfpc_pkg::*;

    cfg_t     cfg;
    logic     fin_push;
    fin_rec_t fin_rec;
    logic     fin_ready;

    usfpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    usfpc_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packet_byte   (s_packet_byte),
        .s_end_of_packet (s_end_of_packet),
        .fin_push        (fin_push),
        .fin_rec         (fin_rec),
        .fin_ready       (fin_ready)
    );

    usfpc_result u_result (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .fin_push        (fin_push),
        .fin_rec         (fin_rec),
        .fin_ready       (fin_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_appearances   (m_appearances),
        .m_rule_hit      (m_rule_hit),
        .m_saved         (m_saved),
        .m_saved_index   (m_saved_index),
        .m_limit_reached (m_limit_reached)
    );

endmodule

// ===== test/udp_source_filter_pattern_counter_core_test.sv =====
// ----------------------------------------------------------------------------
// udp_source_filter_pattern_counter_core_test
// Self-checking bench for the UDP source filter and pattern counter. Packets
// are sent byte by byte, and a predictor in the bench tracks the header
// fields, payload window and save count. Each result is compared with the
// oldest expected verdict. Directed tests come first, then random packets
// under several idling mixes and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module udp_source_filter_pattern_counter_core_test;
    import usfpc_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BYTES  = 30;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic [15:0] appearances;
        logic        rule_hit;
        logic        saved;
        logic [15:0] saved_index;
        logic        limit_reached;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_packet_byte = '0;
    logic        s_end_of_packet = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_appearances;
    logic        m_rule_hit;
    logic        m_saved;
    logic [15:0] m_saved_index;
    logic        m_limit_reached;

    // register mirror
    logic [31:0] flt_address;
    logic [15:0] flt_port;
    logic [63:0] pat_head;
    logic [63:0] pat_tail;
    logic [4:0]  pat_len;
    logic [15:0] keep_limit;

    // packet parse mirror
    logic [15:0] rx_pos;
    logic [5:0]  hdr_bytes;
    logic [31:0] rx_address;
    logic [15:0] rx_port;
    logic [15:0] rx_udp_len;
    logic [7:0]  window [PATTERN_MAX];
    logic [15:0] payload_count;
    logic [15:0] hit_count;
    logic [15:0] saved_total;

    verdict_t    expected_verdicts[$];
    logic [7:0]  frame_bytes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int verdicts_checked = 0;
    int hits_seen = 0;
    int saves_seen = 0;

    udp_source_filter_pattern_counter_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packet_byte   (s_packet_byte),
        .s_end_of_packet (s_end_of_packet),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_appearances   (m_appearances),
        .m_rule_hit      (m_rule_hit),
        .m_saved         (m_saved),
        .m_saved_index   (m_saved_index),
        .m_limit_reached (m_limit_reached)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned active_len();
        if (pat_len == 5'd0)
            return 1;
        if (pat_len > 5'(PATTERN_MAX))
            return PATTERN_MAX;
        return pat_len;
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned k);
        logic [127:0] pat;
        pat = {pat_tail, pat_head};
        return (k < 16) ? pat[8*k +: 8] : 8'd0;
    endfunction

    task automatic clear_parse();
        rx_pos = '0;
        hdr_bytes = '0;
        rx_address = '0;
        rx_port = '0;
        rx_udp_len = '0;
        payload_count = '0;
        hit_count = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
            window[i] = '0;
    endtask

    task automatic shift_payload(input logic [7:0] b);
        int unsigned len;
        logic        match;
        len = active_len();
        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX - 1; i++)
            window[i] = window[i+1];
        window[PATTERN_MAX-1] = b;
        if (payload_count != 16'hFFFF)
            payload_count++;
        if (payload_count >= len) begin
            for (int i = 0; i < len; i++)
                if (window[PATTERN_MAX - len + i] != pat_byte(i))
                    match = 1'b0;
            if (match && hit_count != 16'hFFFF)
                hit_count++;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        int unsigned h;
        int unsigned plen;
        verdict_t    v;
        if (rx_pos != 16'hFFFF) begin
            p = rx_pos;
            if (p == 0)
                hdr_bytes = {b[3:0], 2'b00};
            h = hdr_bytes;
            if (p >= 12 && p <= 15)
                rx_address[8*(15-p) +: 8] = b;
            if (p == h)
                rx_port[15:8] = b;
            if (p == h + 1)
                rx_port[7:0] = b;
            if (p == h + 4)
                rx_udp_len[15:8] = b;
            if (p == h + 5)
                rx_udp_len[7:0] = b;
            plen = (rx_udp_len >= 16'd8) ? rx_udp_len - 16'd8 : 0;
            if (p >= h + 8 && p - (h + 8) < plen)
                shift_payload(b);
            rx_pos++;
        end
        if (last) begin
            v = '0;
            v.rule_hit = (rx_address == flt_address) && (rx_port == flt_port);
            v.appearances = v.rule_hit ? hit_count : 16'd0;
            v.saved = (v.appearances != 0) && (saved_total < keep_limit);
            if (v.saved) begin
                v.saved_index = saved_total;
                saved_total++;
            end
            v.limit_reached = (saved_total >= keep_limit);
            expected_verdicts.push_back(v);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        verdict_t e;
        if (aresetn && m_valid && m_ready) begin
            verdicts_checked++;
            hits_seen += m_rule_hit;
            saves_seen += m_saved;
            if (expected_verdicts.size() == 0) begin
                $error("result item with none expected");
                errors++;
            end else begin
                e = expected_verdicts.pop_front();
                if (m_appearances !== e.appearances) begin
                    $error("appearances: expected %0d, got %0d", e.appearances, m_appearances);
                    errors++;
                end
                if (m_rule_hit !== e.rule_hit) begin
                    $error("rule_hit: expected %0d, got %0d", e.rule_hit, m_rule_hit);
                    errors++;
                end
                if (m_saved !== e.saved) begin
                    $error("saved: expected %0d, got %0d", e.saved, m_saved);
                    errors++;
                end
                if (m_saved_index !== e.saved_index) begin
                    $error("saved_index: expected %0d, got %0d", e.saved_index, m_saved_index);
                    errors++;
                end
                if (m_limit_reached !== e.limit_reached) begin
                    $error("limit_reached: expected %0d, got %0d",
                           e.limit_reached, m_limit_reached);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic settle();
        while (expected_verdicts.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MATCH_ADDRESS:  flt_address = data[31:0];
            REG_MATCH_PORT:     flt_port = data[15:0];
            REG_PATTERN_HEAD:   pat_head = data;
            REG_PATTERN_TAIL:   pat_tail = data;
            REG_PATTERN_LENGTH: pat_len = data[4:0];
            REG_SAVE_LIMIT:     keep_limit = data[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_filter(input logic [31:0] address, input logic [15:0] port,
                              input logic [63:0] head, input logic [63:0] tail,
                              input logic [4:0] len, input logic [15:0] limit);
        write_reg(REG_MATCH_ADDRESS, 64'(address));
        write_reg(REG_MATCH_PORT, 64'(port));
        write_reg(REG_PATTERN_HEAD, head);
        write_reg(REG_PATTERN_TAIL, tail);
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_SAVE_LIMIT, 64'(limit));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_packet_byte = b;
        s_end_of_packet = last;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        packets_sent++;
    endtask

    // IPv4 header of ihl words, UDP header, payload salted with the pattern,
    // then extra bytes past the payload.
    task automatic compose_packet(input int ihl, input logic [31:0] address,
                                  input logic [15:0] port, input logic [15:0] ulen,
                                  input int pay_n, input int extra);
        int h;
        int total;
        int i;
        int r;
        h = ihl * 4;
        total = h + 8 + pay_n + extra;
        frame_bytes.delete();
        for (i = 0; i < total; i++)
            frame_bytes.push_back(8'($urandom));
        for (i = 0; i < 4; i++)
            if (12 + i < total)
                frame_bytes[12+i] = address[8*(3-i) +: 8];
        frame_bytes[h]   = port[15:8];
        frame_bytes[h+1] = port[7:0];
        frame_bytes[h+4] = ulen[15:8];
        frame_bytes[h+5] = ulen[7:0];
        i = 0;
        while (i < pay_n) begin
            r = $urandom_range(9);
            if (r < 4) begin
                for (int k = 0; k < active_len() && i < pay_n; k++) begin
                    frame_bytes[h+8+i] = pat_byte(k);
                    i++;
                end
            end else if (r < 6) begin
                frame_bytes[h+8+i] = 8'($urandom);
                i++;
            end else begin
                frame_bytes[h+8+i] = pat_byte($urandom_range(active_len() - 1));
                i++;
            end
        end
        frame_bytes[0] = {(($urandom_range(7) == 0) ? 4'($urandom) : 4'h4), 4'(ihl)};
    endtask

    task automatic send_packet(input int ihl, input logic [15:0] ulen,
                               input int pay_n, input int extra);
        compose_packet(ihl, flt_address, flt_port, ulen, pay_n, extra);
        send_frame();
    endtask

    task automatic send_random_packet();
        int          r;
        int          ihl;
        int          pay_n;
        int          extra;
        int          idx;
        int          keep;
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] ulen;
        r = $urandom_range(99);
        if (r < 6) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
            send_frame();
            return;
        end
        ihl = (r < 70) ? 5 : (r < 85) ? $urandom_range(6, 9) :
              (r < 93) ? $urandom_range(0, 4) : $urandom_range(10, 15);
        pay_n = $urandom_range(0, 24);
        address = flt_address;
        port = flt_port;
        r = $urandom_range(99);
        if (r < 10) begin
            idx = $urandom_range(31);
            address[idx] = ~address[idx];
        end else if (r < 20) begin
            idx = $urandom_range(15);
            port[idx] = ~port[idx];
        end else if (r < 25) begin
            address = $urandom;
            port = 16'($urandom);
        end
        ulen = 16'(pay_n + 8);
        extra = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : 0;
        r = $urandom_range(99);
        if (r < 10)
            ulen = 16'($urandom_range(7));
        else if (r < 20)
            ulen = 16'($urandom_range(8, pay_n + 8));
        else if (r < 25)
            ulen = 16'($urandom);
        compose_packet(ihl, address, port, ulen, pay_n, extra);
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > keep)
                void'(frame_bytes.pop_back());
        end
        send_frame();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_idle_pct = 25;
        recv_stall_pct = 25;
        send_packet(5, 16'd14, 6, 0);
        frame_bytes.delete();
        frame_bytes.push_back(8'h45);
        send_frame();
    endtask

    task automatic test_register_extremes();
        set_filter('1, '1, '1, '1, 5'd16, 16'hFFFF);
        send_packet(5, 16'd48, 40, 0);
        compose_packet(5, flt_address, flt_port, 16'd48, 40, 0);
        for (int i = 28; i < 68; i++)
            frame_bytes[i] = 8'hFF;
        send_frame();
        set_filter(32'h0A000001, 16'h0035, {$urandom, $urandom}, {$urandom, $urandom},
                   5'd16, 16'hFFFF);
        send_packet(5, 16'd44, 36, 0);
        send_packet(6, 16'd30, 22, 0);
        write_reg(REG_PATTERN_HEAD, {8{8'hAA}});
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        compose_packet(5, flt_address, flt_port, 16'd20, 12, 0);
        for (int i = 28; i < 40; i++)
            frame_bytes[i] = 8'hAA;
        send_frame();
    endtask

    task automatic test_short_udp_length();
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        for (int u = 0; u < 8; u++)
            send_packet(5, 16'(u), 8, 0);
    endtask

    task automatic test_truncated_and_trailing();
        send_packet(5, 16'd13, 12, 0);
        send_packet(5, 16'd38, 10, 0);
        compose_packet(5, flt_address, flt_port, 16'd20, 12, 0);
        while (frame_bytes.size() > 14)
            void'(frame_bytes.pop_back());
        send_frame();
        send_packet(5, 16'd16, 8, 5);
    endtask

    task automatic test_small_header();
        for (int ihl = 0; ihl < 5; ihl++)
            send_packet(ihl, 16'd20, 12, 0);
    endtask

    task automatic test_save_limit();
        write_reg(REG_PATTERN_HEAD, {8{8'h5A}});
        write_reg(REG_SAVE_LIMIT, 64'(saved_total + 16'd2));
        repeat (4) begin
            compose_packet(5, flt_address, flt_port, 16'd12, 4, 0);
            frame_bytes[29] = 8'h5A;
            send_frame();
        end
        write_reg(REG_SAVE_LIMIT, 64'd0);
        send_packet(5, 16'd16, 8, 0);
        write_reg(REG_SAVE_LIMIT, 64'hFFFF);
    endtask

    task automatic test_random_traffic();
        int phase_start;
        int idle_mix [4][2];
        idle_mix = '{'{0, 0}, '{67, 0}, '{0, 67}, '{25, 25}};
        for (int ph = 0; ph < 4; ph++) begin
            set_filter($urandom, 16'($urandom),
                       ($urandom_range(1) ? {8{8'($urandom)}} : {$urandom, $urandom}),
                       {$urandom, $urandom},
                       (ph == 0) ? 5'd1 : (ph == 1) ? 5'd16 : 5'($urandom_range(1, 16)),
                       (ph == 2) ? 16'hFFFF : 16'(saved_total + $urandom_range(0, 12)));
            send_idle_pct = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_packet();
        end
    endtask

    initial begin
        flt_address = '0;
        flt_port = '0;
        pat_head = '0;
        pat_tail = '0;
        pat_len = 5'd1;
        keep_limit = '0;
        saved_total = '0;
        clear_parse();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_short_udp_length();
        test_truncated_and_trailing();
        test_small_header();
        test_save_limit();
        test_random_traffic();

        settle();
        repeat (10) @(negedge aclk);
        $display("covered %0d packets, %0d bytes, four idling mixes and %0d result checks",
                 packets_sent, bytes_sent, verdicts_checked);
        $display("filter hits %0d, packets saved %0d", hits_seen, saves_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
